// ----- sv/btpa_pkg.sv -----
package btpa_pkg;

	typedef enum logic [2:0] {
		MODE_ALLOC  = 3'd0,
		MODE_FREE   = 3'd1,
		MODE_COUNT  = 3'd2,
		MODE_CREATE = 3'd3,
		MODE_DELETE = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		STATUS_OK       = 3'd0,
		STATUS_NO_SPACE = 3'd1,
		STATUS_BAD_FREE = 3'd2,
		STATUS_IN_USE   = 3'd3,
		STATUS_NO_SLOT  = 3'd4
	} status_t;

	localparam int FIELD_W = 16;
	localparam int MODE_W  = 3;
	localparam int ID_W    = 3;

endpackage

// ----- sv/block_table_pool_allocator_core.sv -----
// first-fit block allocator over a block table of NUM_BLOCKS entries with up to MAX_POOLS pools
// input channel: in_valid/in_ready carry one command item (mode, pool_id, byte_count, byte_offset)
// output channel: out_valid/out_ready carry one result item (status, result_value) per command
// in_ready is high whenever the sequencer is idle, even while a finished result still waits
// work per command on the block table memory:
//   allocate: span scanned one entry per cycle until a run fits, then the run written one per cycle
//   count and delete: span scanned one entry per cycle
//   free: two reads, then one entry of the run cleared per cycle
//   create: one entry of the new pool cleared per cycle
//   other modes: straight to the result
// span is the pool's extent in blocks, at most NUM_BLOCKS
// one command is worked at a time; the next is taken once the result sits in the output register
// after reset every table entry is cleared, one entry a cycle, with in_ready low
// reset leaves pool 0 covering all memory and every other pool empty
// if the receiver stalls, the result is held and a finished second command waits for the slot
// BLOCK_BYTES must be a power of two
module block_table_pool_allocator_core
	import btpa_pkg::*;
#(
	parameter int BLOCK_BYTES = 32,
	parameter int NUM_BLOCKS  = 1024,
	parameter int MAX_POOLS   = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [MODE_W-1:0]  mode,
	input  logic [ID_W-1:0]    pool_id,
	input  logic [FIELD_W-1:0] byte_count,
	input  logic [FIELD_W-1:0] byte_offset,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [2:0]         status,
	output logic [FIELD_W-1:0] result_value
);

	// widths derived from the geometry
	localparam int S    = $clog2(BLOCK_BYTES);
	localparam int IW   = $clog2(NUM_BLOCKS);
	localparam int EW   = $clog2(NUM_BLOCKS + 2);
	localparam int PW   = $clog2(MAX_POOLS);
	localparam int NW   = 17;
	localparam logic [31:0] MEM_BYTES = 32'(BLOCK_BYTES * NUM_BLOCKS);
	localparam logic [FIELD_W-1:0] POOL0_LEN = FIELD_W'(BLOCK_BYTES * NUM_BLOCKS);

	typedef enum logic [8:0] {
		SQ_INIT = 9'b000000001,
		SQ_IDLE = 9'b000000010,
		SQ_DISP = 9'b000000100,
		SQ_SCAN = 9'b000001000,
		SQ_AWR  = 9'b000010000,
		SQ_FRD1 = 9'b000100000,
		SQ_FRD2 = 9'b001000000,
		SQ_CLR  = 9'b010000000,
		SQ_DONE = 9'b100000000
	} seq_t;

	seq_t state_q;

	// bytes to table index, rounded up and clamped to the table end
	function automatic logic [IW:0] blk_clamp(input logic [17:0] bytes);
		logic [17:0] q;
		q = (bytes + 18'(BLOCK_BYTES - 1)) >> S;
		return (q > 18'(NUM_BLOCKS)) ? (IW+1)'(NUM_BLOCKS) : q[IW:0];
	endfunction

	// block table memory
	logic [EW-1:0] mem [NUM_BLOCKS];
	logic          we;
	logic [IW-1:0] waddr;
	logic [EW-1:0] wdata;
	logic [IW-1:0] raddr;
	logic [EW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	// pool descriptors
	logic [FIELD_W-1:0] base_q [MAX_POOLS];
	logic [FIELD_W-1:0] len_q  [MAX_POOLS];

	// latched command
	logic [MODE_W-1:0]  mode_q;
	logic               id_ok_q;
	logic [PW-1:0]      pi_q;
	logic [FIELD_W-1:0] cnt_q;
	logic [FIELD_W-1:0] off_q;

	// working registers
	logic [IW:0]        ptr_q;
	logic [IW:0]        hi_q;
	logic               rv_s1;
	logic [IW:0]        idx_s1;
	logic [IW:0]        run_q;
	logic [NW-1:0]      need_q;
	logic [IW:0]        nfree_q;
	logic [IW:0]        start_q;
	logic [NW-1:0]      wcnt_q;
	logic [IW:0]        clr_ptr_q;
	logic [NW-1:0]      clr_left_q;
	logic [IW-1:0]      fidx_q;
	logic [EW-1:0]      fn_q;
	logic [2:0]         st_q;
	logic [FIELD_W-1:0] res_q;
	logic               out_valid_q;
	logic [2:0]         out_status_q;
	logic [FIELD_W-1:0] out_res_q;

	assign in_ready     = (state_q == SQ_IDLE);
	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign result_value = out_res_q;

	// pool span and free checks for the latched pool
	logic [FIELD_W-1:0] cur_base;
	logic [FIELD_W-1:0] cur_len;
	logic [16:0]        cur_end;
	logic [IW:0]        span_lo;
	logic [IW:0]        span_hi;
	logic [NW-1:0]      need_blocks;
	logic               free_outside;
	logic [IW-1:0]      free_idx;

	assign cur_base     = base_q[pi_q];
	assign cur_len      = len_q[pi_q];
	assign cur_end      = {1'b0, cur_base} + {1'b0, cur_len};
	assign span_lo      = blk_clamp({2'b00, cur_base});
	assign span_hi      = blk_clamp({1'b0, cur_end});
	assign need_blocks  = NW'(({1'b0, cnt_q} + 17'(BLOCK_BYTES - 1)) >> S);
	assign free_outside = (off_q < cur_base) || ({1'b0, off_q} > cur_end)
		|| ({16'd0, off_q} >= MEM_BYTES);
	assign free_idx     = IW'(off_q >> S);

	// first empty pool slot from 1 upward
	logic          slot_found;
	logic [PW-1:0] slot_idx;

	always_comb begin
		slot_found = 1'b0;
		slot_idx   = '0;
		for (int i = MAX_POOLS - 1; i >= 1; i--) begin
			if (len_q[i] == '0) begin
				slot_found = 1'b1;
				slot_idx   = PW'(i);
			end
		end
	end

	// scan stage
	logic          scan_issue;
	logic [IW:0]   run_next;
	logic          run_hit;
	logic [IW:0]   run_start;
	logic [31:0]   alloc_bytes;
	logic [31:0]   free_bytes;

	assign scan_issue  = (ptr_q < hi_q);
	assign run_next    = (rdata_q == '0) ? run_q + 1'b1 : '0;
	assign run_hit     = (NW'(run_next) == need_q);
	assign run_start   = idx_s1 - (IW+1)'(need_q) + 1'b1;
	assign alloc_bytes = 32'(start_q) << S;
	assign free_bytes  = 32'(nfree_q) << S;

	// free check once the second entry is back
	logic [EW-1:0] fsecond;
	logic          free_bad;

	assign fsecond  = (fidx_q == IW'(NUM_BLOCKS - 1)) ? '0 : rdata_q;
	assign free_bad = ((fn_q > EW'(1)) && (fsecond != fn_q + 1'b1))
		|| (off_q[S-1:0] != '0);

	logic clr_go;
	assign clr_go = (clr_left_q != '0) && (clr_ptr_q < (IW+1)'(NUM_BLOCKS));

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = clr_ptr_q[IW-1:0];
		wdata = '0;
		raddr = ptr_q[IW-1:0];
		case (state_q)
			SQ_INIT: begin
				we = 1'b1;
			end
			SQ_CLR: begin
				we = clr_go;
			end
			SQ_AWR: begin
				we    = 1'b1;
				waddr = IW'(start_q + (IW+1)'(wcnt_q));
				wdata = ((wcnt_q == NW'(1)) && (need_q > NW'(1)))
					? EW'(need_q + 1'b1) : EW'(need_q);
			end
			SQ_DISP: begin
				raddr = free_idx;
			end
			SQ_FRD1: begin
				raddr = fidx_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= SQ_INIT;
			out_valid_q  <= 1'b0;
			rv_s1        <= 1'b0;
			clr_ptr_q    <= '0;
			for (int i = 0; i < MAX_POOLS; i++) begin
				base_q[i] <= '0;
				len_q[i]  <= '0;
			end
			len_q[0]     <= POOL0_LEN;
		end else begin
			// result held until taken, loaded when the sequencer finishes
			out_valid_q <= (state_q == SQ_DONE) || (out_valid_q && !out_ready);

			case (state_q)
				SQ_INIT: begin
					clr_ptr_q <= clr_ptr_q + 1'b1;
					if (clr_ptr_q == (IW+1)'(NUM_BLOCKS - 1))
						state_q <= SQ_IDLE;
				end

				SQ_IDLE: begin
					if (in_valid) begin
						mode_q  <= mode;
						id_ok_q <= (32'(pool_id) < MAX_POOLS);
						pi_q    <= PW'(pool_id);
						cnt_q   <= byte_count;
						off_q   <= byte_offset;
						state_q <= SQ_DISP;
					end
				end

				SQ_DISP: begin
					st_q    <= STATUS_OK;
					res_q   <= '0;
					ptr_q   <= span_lo;
					hi_q    <= span_hi;
					run_q   <= '0;
					nfree_q <= '0;
					need_q  <= need_blocks;
					rv_s1   <= 1'b0;
					case (mode_q)
						MODE_ALLOC: begin
							st_q <= STATUS_NO_SPACE;
							if (!id_ok_q || cnt_q == '0)
								state_q <= SQ_DONE;
							else
								state_q <= SQ_SCAN;
						end
						MODE_COUNT, MODE_DELETE: begin
							state_q <= id_ok_q ? SQ_SCAN : SQ_DONE;
						end
						MODE_FREE: begin
							fidx_q <= free_idx;
							if (!id_ok_q) begin
								st_q    <= STATUS_BAD_FREE;
								state_q <= SQ_DONE;
							end else if (free_outside) begin
								state_q <= SQ_DONE;
							end else begin
								state_q <= SQ_FRD1;
							end
						end
						MODE_CREATE: begin
							if (!slot_found) begin
								st_q    <= STATUS_NO_SLOT;
								state_q <= SQ_DONE;
							end else begin
								base_q[slot_idx] <= off_q;
								len_q[slot_idx]  <= cnt_q;
								clr_ptr_q        <= blk_clamp({2'b00, off_q});
								clr_left_q       <= need_blocks;
								res_q            <= FIELD_W'(slot_idx);
								state_q          <= SQ_CLR;
							end
						end
						default: begin
							state_q <= SQ_DONE;
						end
					endcase
				end

				SQ_SCAN: begin
					// one entry read per cycle, processed in the next cycle
					if (scan_issue)
						ptr_q <= ptr_q + 1'b1;
					rv_s1  <= scan_issue;
					idx_s1 <= ptr_q;
					if (rv_s1) begin
						case (mode_q)
							MODE_ALLOC: begin
								run_q <= run_next;
								if (run_hit) begin
									start_q <= run_start;
									wcnt_q  <= '0;
									state_q <= SQ_AWR;
								end
							end
							MODE_COUNT: begin
								if (rdata_q == '0)
									nfree_q <= nfree_q + 1'b1;
							end
							default: begin
								if (rdata_q != '0) begin
									st_q    <= STATUS_IN_USE;
									state_q <= SQ_DONE;
								end
							end
						endcase
					end else if (!scan_issue) begin
						// scan finished with nothing in flight
						case (mode_q)
							MODE_COUNT: begin
								res_q <= free_bytes[FIELD_W-1:0];
							end
							MODE_DELETE: begin
								len_q[pi_q] <= '0;
							end
							default: begin
							end
						endcase
						state_q <= SQ_DONE;
					end
				end

				SQ_AWR: begin
					wcnt_q <= wcnt_q + 1'b1;
					if (wcnt_q == need_q - 1'b1) begin
						st_q    <= STATUS_OK;
						res_q   <= alloc_bytes[FIELD_W-1:0];
						state_q <= SQ_DONE;
					end
				end

				SQ_FRD1: begin
					// rdata_q holds the run's first entry here
					fn_q    <= rdata_q;
					state_q <= SQ_FRD2;
				end

				SQ_FRD2: begin
					// rdata_q holds the second entry, checked against the marker
					if (free_bad) begin
						st_q    <= STATUS_BAD_FREE;
						state_q <= SQ_DONE;
					end else begin
						clr_ptr_q  <= (IW+1)'(fidx_q);
						clr_left_q <= NW'(fn_q);
						state_q    <= SQ_CLR;
					end
				end

				SQ_CLR: begin
					if (clr_go) begin
						clr_ptr_q  <= clr_ptr_q + 1'b1;
						clr_left_q <= clr_left_q - 1'b1;
					end else begin
						state_q <= SQ_DONE;
					end
				end

				SQ_DONE: begin
					if (!out_valid_q || out_ready) begin
						out_status_q <= st_q;
						out_res_q    <= res_q;
						state_q      <= SQ_IDLE;
					end
				end

				default: begin
					state_q <= SQ_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- tb/sv/block_table_pool_allocator_core_test.sv -----
module block_table_pool_allocator_core_test;
	import btpa_pkg::*;

	localparam int BLK_BYTES = 32;
	localparam int N_BLOCKS  = 1024;
	localparam int N_POOLS   = 8;
	// one scan of the whole table plus a little overhead
	localparam int SETTLE_CYCLES = N_BLOCKS + 64;

	typedef struct {
		logic [MODE_W-1:0]  m;
		logic [ID_W-1:0]    id;
		logic [FIELD_W-1:0] cnt;
		logic [FIELD_W-1:0] off;
	} command_t;

	typedef struct {
		status_t            st;
		logic [FIELD_W-1:0] val;
	} outcome_t;

	// a run handed out by allocate, kept so that frees can hit real runs
	typedef struct {
		int unsigned pool;
		int unsigned off;
	} run_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [MODE_W-1:0]  mode = '0;
	logic [ID_W-1:0]    pool_id = '0;
	logic [FIELD_W-1:0] byte_count = '0;
	logic [FIELD_W-1:0] byte_offset = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [2:0]         status;
	logic [FIELD_W-1:0] result_value;

	block_table_pool_allocator_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.pool_id      (pool_id),
		.byte_count   (byte_count),
		.byte_offset  (byte_offset),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.result_value (result_value)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// own copy of the allocator state
	int unsigned blk_table [N_BLOCKS];
	int unsigned pool_lo_byte [N_POOLS];
	int unsigned pool_len [N_POOLS];

	command_t    pending_cmds [$];
	outcome_t    awaited_results [$];
	run_t        live_runs [$];
	int          failures = 0;
	// idling: percent of cycles the sender idles and the receiver stalls
	int          send_idle_pct = 0;
	int          recv_stall_pct = 0;

	function automatic int unsigned blocks_of(int unsigned bytes);
		return (bytes + BLK_BYTES - 1) / BLK_BYTES;
	endfunction

	function automatic int unsigned clamp_blk(int unsigned b);
		return (b > N_BLOCKS) ? N_BLOCKS : b;
	endfunction

	function automatic void clear_blocks(int unsigned start, int unsigned n);
		for (int unsigned i = 0; i < n && start + i < N_BLOCKS; i++)
			blk_table[start + i] = 0;
	endfunction

	function automatic void allocator_reset();
		foreach (blk_table[i]) blk_table[i] = 0;
		foreach (pool_len[i]) begin
			pool_lo_byte[i] = 0;
			pool_len[i] = 0;
		end
		pool_len[0] = (BLK_BYTES * N_BLOCKS) & 16'hffff;
	endfunction

	// works out the result of one accepted command and updates the state
	function automatic void apply_command(command_t c);
		outcome_t    o;
		int unsigned lo, hi, need, run, start, idx, n, nfree, slot;
		o.st = STATUS_OK;
		o.val = '0;
		case (c.m)
			MODE_ALLOC: begin
				o.st = STATUS_NO_SPACE;
				if (c.id < N_POOLS && c.cnt != 0) begin
					lo = clamp_blk(blocks_of(pool_lo_byte[c.id]));
					hi = clamp_blk(blocks_of(pool_lo_byte[c.id] + pool_len[c.id]));
					need = blocks_of(32'(c.cnt));
					run = 0;
					for (int unsigned i = lo; i <= hi; i++) begin
						if (run == need) begin
							start = i - need;
							for (int unsigned k = 0; k < need; k++)
								blk_table[start + k] = need;
							// marker in the second entry of a longer run
							if (need > 1)
								blk_table[start + 1] = need + 1;
							o.st = STATUS_OK;
							o.val = 16'(start * BLK_BYTES);
							live_runs.push_back('{32'(c.id), start * BLK_BYTES});
							break;
						end
						if (i < hi)
							run = (blk_table[i] == 0) ? run + 1 : 0;
					end
				end
			end
			MODE_FREE: begin
				if (c.id >= N_POOLS)
					o.st = STATUS_BAD_FREE;
				else if (c.off >= pool_lo_byte[c.id] &&
						c.off <= pool_lo_byte[c.id] + pool_len[c.id] &&
						c.off < BLK_BYTES * N_BLOCKS) begin
					idx = c.off / BLK_BYTES;
					n = blk_table[idx];
					// marker lookup past the table end reads as zero
					if ((n > 1 && ((idx + 1 < N_BLOCKS) ? blk_table[idx + 1] : 0) != n + 1) ||
							c.off % BLK_BYTES != 0)
						o.st = STATUS_BAD_FREE;
					else
						clear_blocks(idx, n);
				end
			end
			MODE_COUNT: begin
				if (c.id < N_POOLS) begin
					lo = clamp_blk(blocks_of(pool_lo_byte[c.id]));
					hi = clamp_blk(blocks_of(pool_lo_byte[c.id] + pool_len[c.id]));
					nfree = 0;
					for (int unsigned i = lo; i < hi; i++)
						if (blk_table[i] == 0) nfree++;
					o.val = 16'(nfree * BLK_BYTES);
				end
			end
			MODE_CREATE: begin
				slot = N_POOLS;
				for (int unsigned i = 1; i < N_POOLS; i++)
					if (pool_len[i] == 0) begin
						slot = i;
						break;
					end
				if (slot >= N_POOLS)
					o.st = STATUS_NO_SLOT;
				else begin
					pool_lo_byte[slot] = 32'(c.off);
					pool_len[slot] = 32'(c.cnt);
					clear_blocks(clamp_blk(blocks_of(32'(c.off))), blocks_of(32'(c.cnt)));
					o.val = 16'(slot);
				end
			end
			MODE_DELETE: begin
				if (c.id < N_POOLS) begin
					lo = clamp_blk(blocks_of(pool_lo_byte[c.id]));
					hi = clamp_blk(blocks_of(pool_lo_byte[c.id] + pool_len[c.id]));
					for (int unsigned i = lo; i < hi; i++)
						if (blk_table[i] != 0) begin
							o.st = STATUS_IN_USE;
							break;
						end
					if (o.st == STATUS_OK)
						pool_len[c.id] = 0;
				end
			end
			default: ;
		endcase
		awaited_results.push_back(o);
	endfunction

	// driver: pops pending items, holds each until the handshake completes
	always @(posedge clk or negedge arst_n) begin
		command_t c;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				apply_command('{mode, pool_id, byte_count, byte_offset});
			if (in_valid && !in_ready) begin
				// keep item and valid steady while the block is busy
			end else if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				c = pending_cmds.pop_front();
				mode <= c.m;
				pool_id <= c.id;
				byte_count <= c.cnt;
				byte_offset <= c.off;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: checks each result item against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		outcome_t e;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (awaited_results.size() == 0) begin
					$error("result item with nothing expected: status %0d value %0d",
						status, result_value);
					failures++;
				end else begin
					e = awaited_results.pop_front();
					if (status !== e.st) begin
						$error("status: expected %0d, got %0d", e.st, status);
						failures++;
					end
					if (result_value !== e.val) begin
						$error("result_value: expected %0d, got %0d", e.val, result_value);
						failures++;
					end
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// queue one item, keeping the pending queue short so frees see fresh runs
	task automatic send(logic [MODE_W-1:0] m, logic [ID_W-1:0] id,
			logic [FIELD_W-1:0] cnt, logic [FIELD_W-1:0] off);
		while (pending_cmds.size() >= 2) @(posedge clk);
		pending_cmds.push_back('{m, id, cnt, off});
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || in_valid || awaited_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic send_random();
		int   r;
		int   k;
		run_t lr;
		logic [FIELD_W-1:0] off;
		logic [FIELD_W-1:0] cnt;
		r = $urandom_range(99);
		if (r < 36) begin
			k = $urandom_range(99);
			if (k < 85) cnt = 16'($urandom_range(1, 200));
			else if (k < 95) cnt = 16'($urandom_range(0, 2048));
			else cnt = 16'($urandom);
			send(MODE_ALLOC, ($urandom_range(3) != 0) ? 3'd0 : 3'($urandom), cnt,
				16'($urandom));
		end else if (r < 66) begin
			if (live_runs.size() != 0 && $urandom_range(99) < 80) begin
				k = $urandom_range(live_runs.size() - 1);
				lr = live_runs[k];
				live_runs.delete(k);
				off = 16'(lr.off);
				k = $urandom_range(99);
				// misaligned offsets and offsets into the run's marker entry
				if (k < 8) off = 16'(off + $urandom_range(1, BLK_BYTES - 1));
				else if (k < 13) off = 16'(off + BLK_BYTES);
				send(MODE_FREE, 3'(lr.pool), 16'($urandom), off);
			end else begin
				send(MODE_FREE, 3'($urandom), 16'($urandom),
					16'($urandom_range(0, BLK_BYTES * N_BLOCKS)));
			end
		end else if (r < 74) begin
			send(MODE_COUNT, ($urandom_range(1) != 0) ? 3'd0 : 3'($urandom),
				16'($urandom), 16'($urandom));
		end else if (r < 86) begin
			off = 16'($urandom_range(0, BLK_BYTES * N_BLOCKS));
			if ($urandom_range(1) != 0) off = off & ~16'(BLK_BYTES - 1);
			k = $urandom_range(99);
			if (k < 70) cnt = 16'($urandom_range(0, 512));
			else if (k < 90) cnt = 16'($urandom_range(0, 4096));
			else cnt = 16'($urandom);
			send(MODE_CREATE, 3'($urandom), cnt, off);
		end else if (r < 97) begin
			send(MODE_DELETE, ($urandom_range(9) == 0) ? 3'd0 : 3'($urandom_range(1, 7)),
				16'($urandom), 16'($urandom));
		end else begin
			send(3'($urandom_range(5, 7)), 3'($urandom), 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		allocator_reset();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, every mode, the named special cases
		send(MODE_ALLOC, 3'd0, 16'd0, 16'd0);          // zero-size allocate
		send(MODE_ALLOC, 3'd0, 16'd1, 16'hffff);       // one block at offset 0
		send(MODE_ALLOC, 3'd0, 16'd33, 16'd0);         // two blocks, marker entry
		send(MODE_ALLOC, 3'd0, 16'd100, 16'd0);        // four blocks
		send(MODE_ALLOC, 3'd0, 16'hffff, 16'd0);       // larger than memory
		send(MODE_ALLOC, 3'd7, 16'd32, 16'd0);         // empty pool
		send(MODE_FREE, 3'd0, 16'd0, 16'd48);          // misaligned
		send(MODE_FREE, 3'd0, 16'd0, 16'd96);          // first entry of the four-block run
		send(MODE_FREE, 3'd0, 16'd0, 16'd32768);       // at memory end, ignored
		send(MODE_FREE, 3'd0, 16'd0, 16'd8192);        // block already free
		send(MODE_FREE, 3'd0, 16'hffff, 16'd32);       // real two-block run
		send(MODE_COUNT, 3'd0, 16'd0, 16'd0);
		send(MODE_COUNT, 3'd5, 16'd0, 16'd0);
		send(MODE_DELETE, 3'd0, 16'd0, 16'd0);         // pool 0 in use
		send(MODE_CREATE, 3'd0, 16'd0, 16'd4096);      // size 0, slot stays empty
		for (int i = 0; i < 7; i++)
			send(MODE_CREATE, 3'd0, 16'd256, 16'(4096 + 512 * i));
		send(MODE_CREATE, 3'd0, 16'd64, 16'd0);        // no pool slot left
		send(MODE_ALLOC, 3'd3, 16'd64, 16'd0);
		send(MODE_DELETE, 3'd3, 16'd0, 16'd0);         // pool in use
		send(MODE_DELETE, 3'd4, 16'd0, 16'd0);         // empty pool deletes
		send(MODE_DELETE, 3'd4, 16'd0, 16'd0);         // already empty slot
		send(3'd5, 3'd7, 16'hffff, 16'hffff);
		send(3'd7, 3'd0, 16'd0, 16'd0);

		// random, four idling phases
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = (p == 1) ? 52 : (p == 3) ? 11 : 0;
			recv_stall_pct = (p == 2) ? 52 : (p == 3) ? 11 : 0;
			for (int i = 0; i < 140; i++) begin
				// a quiet stretch inside each phase after the first
				if (i == 100 && p != 0) begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				send_random();
			end
			if (p == 1) begin
				// hold off until every result has come back
				wait_drained();
				repeat (SETTLE_CYCLES) @(posedge clk);
			end
		end

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#(4 * 4_000_000);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
